### rtl/ahob_pkg.sv
// ----------------------------------------------------------------------------
// ahob_pkg
// Shared types, constants and codes for the additive harmonic oscillator bank.
// ----------------------------------------------------------------------------
package ahob_pkg;

  localparam int DEF_MAX_PARTIALS    = 32;
  localparam int DEF_SINE_INDEX_BITS = 10;
  localparam int DEF_SAMPLE_BITS     = 24;

  localparam int LANE_DEPTH  = 9;
  localparam int ACC_W       = 56;
  localparam int ACC_FRAC    = 46;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [23:0] DETUNE_Q32    = 24'd12884902;
  localparam logic [14:0] PAN_Q16       = 15'd19661;
  localparam logic [14:0] BOOST_Q16     = 15'd19661;
  localparam logic [4:0]  DENSITY_SCALE = 5'd22;
  localparam logic [15:0] UNITY_Q14     = 16'd16384;
  localparam logic [15:0] PAN_HALF      = 16'd32768;
  localparam logic [15:0] COUNT_RESET   = 16'd2;

  localparam logic [31:0] SINE_C0 = 32'd1686629713;
  localparam logic [31:0] SINE_C1 = 32'd693598668;
  localparam logic [31:0] SINE_C2 = 32'd85569306;
  localparam logic [31:0] SINE_C3 = 32'd5026995;
  localparam logic [31:0] SINE_C4 = 32'd172272;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LAYER_MODE = 3'd0,
    CFG_BASE_STEP  = 3'd1,
    CFG_COUNT      = 3'd2,
    CFG_TONE       = 3'd3,
    CFG_LEVEL      = 3'd4,
    CFG_PAN_SPREAD = 3'd5
  } ahob_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ahob_state_t;

  typedef struct packed {
    logic        layer_mode;
    logic [31:0] base_phase_step;
    logic [15:0] count_setting;
    logic [15:0] tone_amount;
    logic [15:0] output_level;
    logic [15:0] pan_spread;
  } ahob_cfg_t;

  typedef struct packed {
    logic [31:0]        phase;
    logic               act;
    logic signed [31:0] prod_l;
    logic signed [31:0] prod_r;
  } ahob_slot_t;

endpackage

### rtl/ahob_cell.sv
// ----------------------------------------------------------------------------
// ahob_cell
// One phase cell of the rotating phase ring.
// ----------------------------------------------------------------------------
module ahob_cell import ahob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  logic [31:0] phase_i,
  output logic [31:0] phase_o
);

  logic [31:0] phase_r;
  logic [31:0] phase_nxt;

  always_comb begin
    phase_nxt = shift_en ? phase_i : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign phase_o = phase_r;

endmodule

### rtl/ahob_lane.sv
// ----------------------------------------------------------------------------
// ahob_lane
// Partial pipeline: phase step, gains, sine and products for one partial.
// ----------------------------------------------------------------------------
module ahob_lane import ahob_pkg::*; #(
  parameter int MAX_PARTIALS    = DEF_MAX_PARTIALS,
  parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  ahob_cfg_t                       cfg,
  input  logic [31:0]                     phase_i,
  input  logic [$clog2(MAX_PARTIALS)-1:0] idx_i,
  input  logic                            act_i,
  output ahob_slot_t                      slot_o
);

  localparam int IW  = $clog2(MAX_PARTIALS);
  localparam int HW  = IW + 1;
  localparam int SMW = 32 + HW;
  localparam int TFW = 16 + IW;
  localparam int FW  = IW + 24;
  localparam int BW  = IW + 17;
  localparam int SIB = SINE_INDEX_BITS;

  function automatic logic [31:0] horner(input logic [31:0] c, input logic [31:0] r,
                                         input logic [30:0] x2);
    logic [62:0] prod;
    prod = 63'(r) * 63'(x2);
    return c - prod[61:30];
  endfunction

  logic [RECIP_W-1:0] recip [MAX_PARTIALS];

  for (genvar g = 0; g < MAX_PARTIALS; g++) begin : g_recip
    localparam longint unsigned Hd       = g + 1;
    localparam longint unsigned RecipVal = ((64'd1 << RECIP_SHIFT) + Hd - 64'd1) / Hd;
    assign recip[g] = RECIP_W'(RecipVal);
  end

  logic [7:0] act_r;

  logic [31:0]  p1_r, p2_r, p3_r, p4_r;
  logic [30:0]  x1_r, x2c_r, x3c_r, x4c_r, x5c_r, x6c_r;
  logic [30:0]  sq2_r, sq3_r, sq4_r, sq5_r;
  logic [1:0]   q1_r, q2_r, q3_r, q4_r, q5_r, q6_r, q7_r;
  logic [SMW-1:0] s1_r, s2_r;
  logic [31:0]  s3_r;
  logic [TFW-1:0] tf1_r;
  logic [IW-1:0] i1_r, i2_r, i3_r;
  logic [FW-1:0] f2_r, exlo3_r;
  logic [HW+FW-1:0] exhi3_r;
  logic [BW-1:0] boost2_r, n3_r;
  logic [31:0]  r3_r, r4_r, r5_r, r6_r, y7_r;
  logic [31:0]  step4_r;
  logic [BW+RECIP_W-1:0] rprod4_r;
  logic [15:0]  amp5_r, gl6_r, gr6_r, gl7_r, gr7_r, gl8_r, gr8_r;
  logic [31:0]  np5_r, np6_r, np7_r, np8_r;
  logic signed [15:0] sv8_r;
  ahob_slot_t   slot9_r;

  logic [SIB-1:0] sidx;
  logic [30:0]    x_raw, x_m;
  logic [HW-1:0]  h;
  logic [62:0]    sq_prod;
  logic [TFW+23:0] f_prod;
  logic [TFW+14:0] b_prod;
  logic [31+FW:0] lo_prod;
  logic [15+BW:0] n_prod;
  logic [BW-1:0]  n_val;
  logic [BW:0]    quo;
  logic [15:0]    amp;
  logic [31:0]    w_prod;
  logic [16:0]    pan_main, pan_other, pan_l, pan_r;
  logic [32:0]    gl_prod, gr_prod;
  logic [63:0]    y_prod;
  logic [32:0]    y_rnd;
  logic [17:0]    y_q;
  logic [14:0]    y_mag;
  logic signed [32:0] pl_prod, pr_prod;

  always_comb begin
    sidx  = phase_i[31 -: SIB];
    x_raw = 31'(sidx[SIB-3:0]) << (32 - SIB);
    x_m   = sidx[SIB-2] ? ((31'd1 << 30) - x_raw) : x_raw;
    h     = HW'(idx_i) + HW'(1);

    sq_prod = 63'(x1_r) * 63'(x1_r);
    f_prod  = (TFW+24)'(tf1_r) * (TFW+24)'(DETUNE_Q32);
    b_prod  = (TFW+15)'(tf1_r) * (TFW+15)'(BOOST_Q16);

    lo_prod = (32+FW)'(s2_r[31:0]) * (32+FW)'(f2_r);
    n_prod  = (16+BW)'(cfg.output_level) * (16+BW)'(boost2_r);
    n_val   = cfg.layer_mode ? n_prod[15+BW:16] : BW'(cfg.output_level);

    quo = rprod4_r[BW+RECIP_W-1:RECIP_SHIFT];
    if (cfg.layer_mode) begin
      amp = (quo > (BW+1)'(UNITY_Q14)) ? UNITY_Q14 : quo[15:0];
    end else begin
      amp = quo[15:0];
    end

    w_prod    = 32'(cfg.pan_spread) * 32'(PAN_Q16);
    pan_main  = 17'(PAN_HALF) + 17'(w_prod[31:16]);
    pan_other = (17'd1 << 16) - pan_main;
    pan_l     = cfg.layer_mode ? pan_other : pan_main;
    pan_r     = cfg.layer_mode ? pan_main : pan_other;
    gl_prod   = 33'(amp5_r) * 33'(pan_l);
    gr_prod   = 33'(amp5_r) * 33'(pan_r);

    y_prod = 64'(r6_r) * 64'(x6c_r);
    y_rnd  = 33'(y7_r) + (33'd1 << 14);
    y_q    = y_rnd[32:15];
    y_mag  = (y_q > 18'd32767) ? 15'h7fff : y_q[14:0];

    pl_prod = 33'(sv8_r) * $signed({17'd0, gl8_r});
    pr_prod = 33'(sv8_r) * $signed({17'd0, gr8_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= '0;
      slot9_r.act <= 1'b0;
    end else if (en) begin
      act_r       <= {act_r[6:0], act_i};
      slot9_r.act <= act_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= phase_i;
      x1_r  <= x_m;
      q1_r  <= sidx[SIB-1 -: 2];
      s1_r  <= SMW'(cfg.base_phase_step) * SMW'(h);
      tf1_r <= TFW'(cfg.tone_amount) * TFW'(idx_i);
      i1_r  <= idx_i;

      p2_r     <= p1_r;
      x2c_r    <= x1_r;
      sq2_r    <= sq_prod[60:30];
      q2_r     <= q1_r;
      s2_r     <= s1_r;
      f2_r     <= f_prod[TFW+23:16];
      boost2_r <= BW'(b_prod[TFW+14:16]) + (BW'(1) << 16);
      i2_r     <= i1_r;

      r3_r    <= horner(SINE_C3, SINE_C4, sq2_r);
      exlo3_r <= lo_prod[31+FW:32];
      exhi3_r <= (HW+FW)'(s2_r[SMW-1:32]) * (HW+FW)'(f2_r);
      n3_r    <= n_val;
      p3_r    <= p2_r;
      x3c_r   <= x2c_r;
      sq3_r   <= sq2_r;
      q3_r    <= q2_r;
      s3_r    <= s2_r[31:0];
      i3_r    <= i2_r;

      r4_r     <= horner(SINE_C2, r3_r, sq3_r);
      step4_r  <= cfg.layer_mode ? s3_r : (s3_r + 32'(exhi3_r) + 32'(exlo3_r));
      rprod4_r <= (BW+RECIP_W)'(n3_r) * (BW+RECIP_W)'(recip[i3_r]);
      p4_r     <= p3_r;
      x4c_r    <= x3c_r;
      sq4_r    <= sq3_r;
      q4_r     <= q3_r;

      r5_r  <= horner(SINE_C1, r4_r, sq4_r);
      amp5_r <= amp;
      np5_r <= p4_r + (act_r[3] ? step4_r : 32'd0);
      x5c_r <= x4c_r;
      sq5_r <= sq4_r;
      q5_r  <= q4_r;

      r6_r  <= horner(SINE_C0, r5_r, sq5_r);
      gl6_r <= gl_prod[31:16];
      gr6_r <= gr_prod[31:16];
      np6_r <= np5_r;
      x6c_r <= x5c_r;
      q6_r  <= q5_r;

      y7_r  <= y_prod[61:30];
      gl7_r <= gl6_r;
      gr7_r <= gr6_r;
      np7_r <= np6_r;
      q7_r  <= q6_r;

      sv8_r <= q7_r[1] ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
      gl8_r <= gl7_r;
      gr8_r <= gr7_r;
      np8_r <= np7_r;

      slot9_r.phase  <= np8_r;
      slot9_r.prod_l <= pl_prod[31:0];
      slot9_r.prod_r <= pr_prod[31:0];
    end
  end

  assign slot_o = slot9_r;

endmodule

### rtl/additive_harmonic_oscillator_bank.sv
// ----------------------------------------------------------------------------
// additive_harmonic_oscillator_bank
// Adds a bank of harmonic sine partials to a stereo sample stream.
// ----------------------------------------------------------------------------
// Each input beat is one stereo sample. The partial phases sit in a ring of
// MAX_PARTIALS cells that rotates once per sample through a nine-stage partial
// lane; each sample takes one full rotation of ring and lane. The result is
// held in an output register, and the next input beat is taken while it waits.
module additive_harmonic_oscillator_bank import ahob_pkg::*; #(
  parameter int MAX_PARTIALS    = DEF_MAX_PARTIALS,
  parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS,
  parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: left_in, right_in
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata: left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]                cfg_addr,
  input  logic [CFG_DATA_W-1:0]                cfg_data
);

  localparam int DW    = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int SB    = SAMPLE_BITS;
  localparam int IW    = $clog2(MAX_PARTIALS);
  localparam int LOOP  = MAX_PARTIALS + LANE_DEPTH;
  localparam int CW    = $clog2(LOOP);
  localparam int CNTW  = $clog2(MAX_PARTIALS + 1);
  localparam int SHIFT = ACC_FRAC - SB;

  function automatic logic [SB-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    v  = acc >>> SHIFT;
    hi = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[SB-1:0];
  endfunction

  ahob_cfg_t   cfg_r;
  ahob_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0] acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic        last_r;
  logic        out_tvalid_r;
  logic [DW-1:0] out_tdata_r;
  logic        out_tlast_r;

  logic        in_fire, run_en, load_out;
  logic [15:0] cnt_raw;
  logic [20:0] dens_prod;
  logic [CNTW-1:0] count;
  logic        slot_real, slot_act;
  logic [31:0] ring_q [MAX_PARTIALS];
  ahob_slot_t  slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layer_mode      <= 1'b0;
      cfg_r.base_phase_step <= '0;
      cfg_r.count_setting   <= COUNT_RESET;
      cfg_r.tone_amount     <= '0;
      cfg_r.output_level    <= '0;
      cfg_r.pan_spread      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_LAYER_MODE: cfg_r.layer_mode      <= cfg_data[0];
        CFG_BASE_STEP:  cfg_r.base_phase_step <= cfg_data[31:0];
        CFG_COUNT:      cfg_r.count_setting   <= cfg_data[15:0];
        CFG_TONE:       cfg_r.tone_amount     <= cfg_data[15:0];
        CFG_LEVEL:      cfg_r.output_level    <= cfg_data[15:0];
        CFG_PAN_SPREAD: cfg_r.pan_spread      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dens_prod = 21'(cfg_r.count_setting) * 21'(DENSITY_SCALE);
    cnt_raw   = cfg_r.layer_mode ? (16'(dens_prod[20:16]) + 16'd2) : cfg_r.count_setting;
    if (cnt_raw > 16'(MAX_PARTIALS)) begin
      cnt_raw = 16'(MAX_PARTIALS);
    end else if (cnt_raw < 16'd2) begin
      cnt_raw = 16'd2;
    end
    count     = cnt_raw[CNTW-1:0];
    slot_real = cnt_r < CW'(MAX_PARTIALS);
    slot_act  = slot_real && (cnt_r < CW'(count));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == CW'(LOOP - 1)) state_nxt = ST_DONE;
      ST_DONE: if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    run_en    = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_RUN:  run_en    = 1'b1;
      ST_DONE: load_out  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    cnt_nxt   = cnt_r;
    acc_l_nxt = acc_l_r;
    acc_r_nxt = acc_r_r;
    if (in_fire) begin
      cnt_nxt   = '0;
      acc_l_nxt = ACC_W'($signed(in_tdata[SB-1:0])) <<< SHIFT;
      acc_r_nxt = ACC_W'($signed(in_tdata[2*SB-1:SB])) <<< SHIFT;
    end else if (run_en) begin
      cnt_nxt = cnt_r + CW'(1);
      if (slot.act) begin
        acc_l_nxt = acc_l_r + (ACC_W'(slot.prod_l) <<< 16);
        acc_r_nxt = acc_r_r + (ACC_W'(slot.prod_r) <<< 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_l_r <= acc_l_nxt;
    acc_r_r <= acc_r_nxt;
    if (in_fire) begin
      last_r <= in_tlast;
    end
    if (load_out) begin
      out_tdata_r <= DW'({finish(acc_r_r), finish(acc_l_r)});
      out_tlast_r <= last_r;
    end
  end

  for (genvar k = 0; k < MAX_PARTIALS; k++) begin : g_ring
    ahob_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (run_en),
      .phase_i  ((k == MAX_PARTIALS - 1) ? slot.phase : ring_q[(k + 1) % MAX_PARTIALS]),
      .phase_o  (ring_q[k])
    );
  end

  ahob_lane #(
    .MAX_PARTIALS    (MAX_PARTIALS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (run_en),
    .cfg     (cfg_r),
    .phase_i (ring_q[0]),
    .idx_i   (cnt_r[IW-1:0]),
    .act_i   (slot_act),
    .slot_o  (slot)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("accepted beat did not start a rotation");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == CW'(LOOP - 1)) |=> state_r == ST_DONE)
    else $error("rotation did not end after one full loop");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_tvalid_r && !out_tready |=> state_r == ST_DONE)
    else $error("result left while output register was still full");

  a_ring_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |=> $stable(ring_q[0]))
    else $error("phase ring moved outside a rotation");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Oscillator bank testbench
// Streams stereo samples through the oscillator bank under several register
// settings and checks every output beat against a bit-exact predictor of the
// partial phases, gains, sine values and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class mix_scoreboard;
  bit [31:0]   phases[32];
  bit          layer;
  bit [31:0]   base_step;
  bit [15:0]   count_set;
  bit [15:0]   tone;
  bit [15:0]   level;
  bit [15:0]   width;
  logic [48:0] pending[$];
  int          mismatches;
  int          checked;

  function void clear();
    foreach (phases[k]) phases[k] = 0;
    layer = 0; base_step = 0; count_set = 2; tone = 0; level = 0; width = 0;
    mismatches = 0;
    checked = 0;
  endfunction

  function void write_reg(ahob_pkg::ahob_cfg_idx_e idx, bit [31:0] val);
    case (idx)
      ahob_pkg::CFG_LAYER_MODE: layer = val[0];
      ahob_pkg::CFG_BASE_STEP:  base_step = val;
      ahob_pkg::CFG_COUNT:      count_set = val[15:0];
      ahob_pkg::CFG_TONE:       tone = val[15:0];
      ahob_pkg::CFG_LEVEL:      level = val[15:0];
      ahob_pkg::CFG_PAN_SPREAD: width = val[15:0];
      default: ;
    endcase
  endfunction

  function longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x2, r;
    x2 = (x * x) >> 30;
    r = 172272;
    r = 5026995 - ((r * x2) >> 30);
    r = 85569306 - ((r * x2) >> 30);
    r = 693598668 - ((r * x2) >> 30);
    r = 1686629713 - ((r * x2) >> 30);
    return (r * x) >> 30;
  endfunction

  function longint sine_value(bit [31:0] ph);
    bit [9:0] idx;
    longint unsigned x, y;
    idx = ph[31:22];
    x = longint'(idx[7:0]) << 22;
    if (idx[8]) x = (64'd1 << 30) - x;
    y = (quarter_wave(x) + (64'd1 << 14)) >> 15;
    if (y > 32767) y = 32767;
    return idx[9] ? -longint'(y) : longint'(y);
  endfunction

  function bit [23:0] saturate(longint acc);
    longint v;
    if (acc >= 0) v = acc >>> 22;
    else v = -longint'(($unsigned(-acc) + 64'h3fffff) >> 22);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function void note_sample(bit [23:0] l, bit [23:0] r, bit last);
    longint unsigned pm, pl, pr, amp, stp, f, boost, gl, gr;
    longint acc_l, acc_r, s;
    int cnt;
    pm = 32768 + ((longint'(width) * 19661) >> 16);
    pl = layer ? 65536 - pm : pm;
    pr = layer ? pm : 65536 - pm;
    acc_l = longint'($signed(l)) <<< 22;
    acc_r = longint'($signed(r)) <<< 22;
    if (!layer) cnt = (count_set < 32) ? count_set : 32;
    else cnt = 2 + ((22 * int'(count_set)) >> 16);
    if (cnt < 2) cnt = 2;
    if (cnt > 32) cnt = 32;
    for (int i = 0; i < cnt; i++) begin
      stp = longint'(base_step) * (i + 1);
      if (!layer) begin
        f = (longint'(tone) * i * 12884902) >> 16;
        stp += (stp >> 32) * f + (((stp & 64'hffffffff) * f) >> 32);
        amp = level / (i + 1);
      end else begin
        boost = 65536 + ((longint'(i) * tone * 19661) >> 16);
        amp = (longint'(level) * boost) / (longint'(i + 1) << 16);
        if (amp > 16384) amp = 16384;
      end
      gl = (amp * pl) >> 16;
      gr = (amp * pr) >> 16;
      s = sine_value(phases[i]);
      acc_l += s * longint'(gl) * 65536;
      acc_r += s * longint'(gr) * 65536;
      phases[i] = phases[i] + stp[31:0];
    end
    pending.push_back({last, saturate(acc_r), saturate(acc_l)});
  endfunction

  function void check_result(logic [47:0] data, logic last);
    logic [48:0] exp;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: output beat with nothing expected");
      return;
    end
    exp = pending.pop_front();
    if ({last, data} !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: beat %0d left %h/%h right %h/%h last %b/%b (exp/act)", checked,
                 exp[23:0], data[23:0], exp[47:24], data[47:24], exp[48], last);
    end
  endfunction
endclass

module testbench;
  import ahob_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_data;

  mix_scoreboard sb;
  int  idle_pct;
  bit  hold_off;
  int  quiet_cycles;
  int  sent;

  additive_harmonic_oscillator_bank i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(ahob_cfg_idx_e idx, bit [31:0] val);
    cfg_wr_en <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_sample(bit [23:0] l, bit [23:0] r, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {r, l};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(l, r, last);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic bit [23:0] pick_sample();
    case ($urandom_range(5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_setting(bit lay);
    write_reg(CFG_LAYER_MODE, 32'(lay));
    write_reg(CFG_BASE_STEP, $urandom_range(3) == 0 ? 32'h8000_0000 : $urandom());
    write_reg(CFG_COUNT, $urandom_range(2) == 0 ? $urandom() : $urandom_range(40));
    write_reg(CFG_TONE, $urandom());
    write_reg(CFG_LEVEL, $urandom_range(3) == 0 ? 32'hffff : $urandom());
    write_reg(CFG_PAN_SPREAD, $urandom());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0; out_tready = 0;
    cfg_wr_en = 0; cfg_addr = 0; cfg_data = 0;
    idle_pct = 33; hold_off = 0; quiet_cycles = 0; sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset defaults first, then field extremes at full level.
    send_sample(24'h7fffff, 24'h800000, 1);
    send_sample(24'h0, 24'hffffff, 0);
    drain();
    write_reg(CFG_BASE_STEP, 32'h8000_0000);
    write_reg(CFG_COUNT, 32'hffff);
    write_reg(CFG_TONE, 32'hffff);
    write_reg(CFG_LEVEL, 32'hffff);
    write_reg(CFG_PAN_SPREAD, 32'hffff);
    for (int k = 0; k < 6; k++) send_sample(k[0] ? 24'h7fffff : 24'h800000, 24'h7fffff, k[1]);
    drain();
    write_reg(CFG_LAYER_MODE, 32'd1);
    write_reg(CFG_COUNT, 32'd0);
    write_reg(CFG_BASE_STEP, 32'h0123_4567);
    for (int k = 0; k < 4; k++) send_sample(24'h800000, 24'h800000, k[0]);
    drain();
    write_reg(CFG_COUNT, 32'hffff);
    write_reg(CFG_PAN_SPREAD, 32'd0);
    for (int k = 0; k < 4; k++) send_sample(pick_sample(), pick_sample(), k[0]);
    drain();
    write_reg(CFG_LAYER_MODE, 32'd0);
    write_reg(CFG_COUNT, 32'd1);
    write_reg(CFG_LEVEL, 32'd0);
    for (int k = 0; k < 3; k++) send_sample(pick_sample(), pick_sample(), 1);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      random_setting(ph[0]);
      idle_pct = (ph == 3) ? 0 : 33;
      if (ph == 5) fork
        begin
          hold_off = 1;
          repeat (2000) @(posedge clk);
          hold_off = 0;
        end
      join_none
      for (int k = 0; k < 100; k++)
        send_sample(pick_sample(), pick_sample(), 1'($urandom_range(1)));
      drain();
    end

    $display("Covered %0d samples over both layer rule sets, count and level extremes,",
             sent);
    $display("random register settings, idle gaps and a long output hold-off.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### additive_harmonic_oscillator_bank.f
rtl/ahob_pkg.sv
rtl/ahob_cell.sv
rtl/ahob_lane.sv
rtl/additive_harmonic_oscillator_bank.sv
tb/testbench.sv
